>>> rtl/core/mbrx_pkg.sv
// Shared types, constants and CRC helper for the Modbus RTU frame receiver.
// Has no dependencies; every other file of the block depends on it.
package mbrx_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W = 9;
  localparam int LEN_W = 9;
  localparam int CRC_W = 16;
  localparam int LONG_W = 7;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PORTION = 4'd1;

  localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RESET = 8'h01;
  localparam logic [LONG_W-1:0] LONG_PORTION_RESET = 7'd0;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [BYTE_W-1:0] LONG_MARKER = 8'hF0;
  localparam logic [LEN_W-1:0] FRAME_OVERHEAD = 9'd5;
  localparam logic [LEN_W-1:0] FIXED_LENGTH = 9'd8;

  localparam logic [BYTE_W-1:0] FN_READ_COILS = 8'h01;
  localparam logic [BYTE_W-1:0] FN_READ_HOLDING = 8'h03;
  localparam logic [BYTE_W-1:0] FN_READ_INPUT = 8'h04;
  localparam logic [BYTE_W-1:0] FN_WRITE_COIL = 8'h05;
  localparam logic [BYTE_W-1:0] FN_WRITE_REG = 8'h06;
  localparam logic [BYTE_W-1:0] FN_WRITE_MULTI = 8'h10;
  localparam logic [BYTE_W-1:0] FN_USER_READ = 8'h70;
  localparam logic [BYTE_W-1:0] FN_USER_WRITE = 8'h71;

  typedef struct packed {
    logic [IDX_W-1:0]  byte_index;
    logic [LEN_W-1:0]  expected_length;
    logic [BYTE_W-1:0] current_function;
    logic [CRC_W-1:0]  running_crc;
    logic [BYTE_W-1:0] crc_low_byte;
  } track_state_t;

  typedef struct packed {
    logic              accepted;
    logic [IDX_W-1:0]  position;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
    logic              frame_good;
    logic [BYTE_W-1:0] function_code;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] device_address;
    logic [LONG_W-1:0] long_portion;
  } cfg_regs_t;

  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/mbrx_ifs.sv
// Valid/ready channel interfaces for the Modbus RTU frame receiver.
// Depends on mbrx_pkg for field widths.
interface mbrx_byte_if;
  logic                      valid;
  logic                      ready;
  logic [mbrx_pkg::BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mbrx_result_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [mbrx_pkg::IDX_W-1:0]  position;
  logic [mbrx_pkg::BYTE_W-1:0] data_byte;
  logic                        frame_end;
  logic                        frame_good;
  logic [mbrx_pkg::BYTE_W-1:0] function_code;
  logic [mbrx_pkg::LEN_W-1:0]  frame_length;
  modport source (output valid, output accepted, output position, output data_byte,
                  output frame_end, output frame_good, output function_code,
                  output frame_length, input ready);
  modport sink (input valid, input accepted, input position, input data_byte,
                input frame_end, input frame_good, input function_code,
                input frame_length, output ready);
endinterface

interface mbrx_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mbrx_pkg::CFG_INDEX_W-1:0] index;
  logic [mbrx_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/mbrx_track.sv
// Frame tracking logic: next tracker state and the result for one byte.
// Purely combinational; depends on mbrx_pkg.
module mbrx_track (
  input  mbrx_pkg::cfg_regs_t    cfg_regs,
  input  mbrx_pkg::track_state_t cur,
  input  logic [mbrx_pkg::BYTE_W-1:0] ch,
  output mbrx_pkg::track_state_t nxt,
  output mbrx_pkg::result_t      res
);
  import mbrx_pkg::*;

  logic             restart;
  logic             fn_ok;
  logic             read_type;
  logic [LEN_W-1:0] len;
  logic [LEN_W:0]   idx_plus1;
  logic [LEN_W:0]   idx_plus2;

  always_comb begin
    case (ch) inside
      FN_READ_COILS, FN_READ_HOLDING, FN_READ_INPUT, FN_WRITE_COIL,
      FN_WRITE_REG, FN_WRITE_MULTI, FN_USER_READ, FN_USER_WRITE: fn_ok = 1'b1;
      default: fn_ok = 1'b0;
    endcase
    case (cur.current_function) inside
      FN_READ_COILS, FN_READ_HOLDING, FN_READ_INPUT, FN_USER_READ: read_type = 1'b1;
      default: read_type = 1'b0;
    endcase
  end

  always_comb begin
    restart = (ch == cfg_regs.device_address) &&
              ((cur.byte_index == '0) || (cur.byte_index >= cur.expected_length));
    if (cur.byte_index == IDX_W'(2)) begin
      if (ch == LONG_MARKER) begin
        len = {1'b0, cfg_regs.long_portion, 1'b0} + FRAME_OVERHEAD;
      end else if (read_type) begin
        len = {1'b0, ch} + FRAME_OVERHEAD;
      end else begin
        len = FIXED_LENGTH;
      end
    end else begin
      len = cur.expected_length;
    end
    idx_plus1 = {1'b0, cur.byte_index} + (LEN_W+1)'(1);
    idx_plus2 = {1'b0, cur.byte_index} + (LEN_W+1)'(2);

    nxt = cur;
    res = '0;
    res.data_byte = ch;
    if (restart) begin
      res.accepted = 1'b1;
      nxt.byte_index = IDX_W'(1);
      nxt.running_crc = crc_step(CRC_INIT, ch);
    end else if (cur.byte_index == IDX_W'(1)) begin
      if (fn_ok) begin
        res.accepted = 1'b1;
        res.position = IDX_W'(1);
        nxt.current_function = ch;
        nxt.running_crc = crc_step(cur.running_crc, ch);
        nxt.byte_index = IDX_W'(2);
      end else begin
        nxt.byte_index = '0;
      end
    end else if (cur.byte_index >= IDX_W'(2)) begin
      nxt.expected_length = len;
      res.accepted = 1'b1;
      res.position = cur.byte_index;
      res.frame_length = len;
      if (idx_plus2 == {1'b0, len}) begin
        nxt.crc_low_byte = ch;
        nxt.byte_index = idx_plus1[IDX_W-1:0];
      end else if (idx_plus1 == {1'b0, len}) begin
        res.frame_end = 1'b1;
        res.frame_good = (cur.running_crc == {ch, cur.crc_low_byte});
        nxt.byte_index = '0;
        nxt.running_crc = '0;
      end else begin
        nxt.running_crc = crc_step(cur.running_crc, ch);
        nxt.byte_index = idx_plus1[IDX_W-1:0];
      end
    end
    res.function_code = res.accepted ? nxt.current_function : '0;
  end

endmodule

>>> rtl/core/modbus_rtu_frame_receiver.sv
// Top level of the Modbus RTU frame receiver: input register, frame tracker,
// result register and configuration registers. Depends on mbrx_pkg,
// the channel interfaces and mbrx_track.
//
// Usage:
//   rx carries one received byte per transfer. res returns exactly one result
//   per byte: whether it belongs to the current frame, its position, the byte
//   itself, the end-of-frame and CRC-good flags, the function code and the
//   expected frame length. cfg writes device_address (index 0) and
//   long_portion (index 1); it is always ready, other indexes are ignored.
//   Write configuration only while no byte is in flight.
//   A taken byte is held in the input register, is processed by the tracker,
//   and its result is captured in the result register and offered from there.
//   Throughput: one byte per cycle while res does not stall; the eight-bit CRC
//   step is unrolled in the logic between the input and result registers.
//   When res stalls, the result register holds, the input register keeps
//   one more byte, and rx.ready then drops until the result is taken.
//   Reset clears the tracker to idle, empties both registers and restores
//   device_address to 1 and long_portion to 0.
module modbus_rtu_frame_receiver (
  input  logic          clk,
  input  logic          rst,
  mbrx_cfg_if.sink      cfg,
  mbrx_byte_if.sink     rx,
  mbrx_result_if.source res
);
  import mbrx_pkg::*;

  cfg_regs_t         cfg_regs;
  track_state_t      state;
  track_state_t      state_next;
  result_t           result;
  result_t           result_next;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  logic              advance;
  logic              fire;

  assign cfg.ready = 1'b1;
  assign advance = !out_valid || res.ready;
  assign fire = in_valid && advance;
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.device_address <= DEVICE_ADDRESS_RESET;
      cfg_regs.long_portion <= LONG_PORTION_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEVICE_ADDRESS: cfg_regs.device_address <= cfg.data;
        REG_LONG_PORTION: cfg_regs.long_portion <= cfg.data[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  mbrx_track u_track (
    .cfg_regs (cfg_regs),
    .cur      (state),
    .ch       (in_byte),
    .nxt      (state_next),
    .res      (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (fire) begin
      result <= result_next;
    end
  end

  assign res.valid = out_valid;
  assign res.accepted = result.accepted;
  assign res.position = result.position;
  assign res.data_byte = result.data_byte;
  assign res.frame_end = result.frame_end;
  assign res.frame_good = result.frame_good;
  assign res.function_code = result.function_code;
  assign res.frame_length = result.frame_length;

endmodule

>>> tb/modbus_rtu_frame_receiver_test.sv
// Testbench for the Modbus RTU frame receiver: sends framed and noisy byte streams,
// predicts every per-byte result and checks it. Depends on mbrx_pkg, the channel
// interfaces and the modbus_rtu_frame_receiver top level.
`timescale 1ns / 100ps

module modbus_rtu_frame_receiver_test;
  import mbrx_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 4'd2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 140;

  logic clk;
  logic rst;
  bit   calm;
  int   cycle_count;
  int   error_count;
  int   frame_bytes_sent;

  logic [BYTE_W-1:0] cfg_addr;
  logic [LONG_W-1:0] cfg_long;

  int unsigned       trk_index;
  int unsigned       trk_length;
  logic [BYTE_W-1:0] trk_function;
  logic [CRC_W-1:0]  trk_crc;
  logic [BYTE_W-1:0] trk_crc_low;

  result_t byte_verdicts[$];

  logic [BYTE_W-1:0] fn_codes[8] = '{FN_READ_COILS, FN_READ_HOLDING, FN_READ_INPUT,
                                     FN_WRITE_COIL, FN_WRITE_REG, FN_WRITE_MULTI,
                                     FN_USER_READ, FN_USER_WRITE};

  mbrx_cfg_if    cfg_ch ();
  mbrx_byte_if   rx_ch ();
  mbrx_result_if res_ch ();

  modbus_rtu_frame_receiver i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .rx  (rx_ch),
    .res (res_ch)
  );

  always #4 clk = ~clk;

  function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic bit is_modbus_function(input logic [BYTE_W-1:0] code);
    foreach (fn_codes[i]) begin
      if (code == fn_codes[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_read_function(input logic [BYTE_W-1:0] code);
    return code == FN_READ_COILS || code == FN_READ_HOLDING ||
           code == FN_READ_INPUT || code == FN_USER_READ;
  endfunction

  function automatic result_t track_frame_byte(input logic [BYTE_W-1:0] ch);
    result_t r;
    r = '0;
    r.data_byte = ch;
    if (ch == cfg_addr && (trk_index == 0 || trk_index >= trk_length)) begin
      r.accepted = 1'b1;
      trk_index = 1;
      trk_crc = crc16_update(CRC_INIT, ch);
    end else if (trk_index == 1) begin
      if (is_modbus_function(ch)) begin
        r.accepted = 1'b1;
        r.position = IDX_W'(1);
        trk_function = ch;
        trk_crc = crc16_update(trk_crc, ch);
        trk_index = 2;
      end else begin
        trk_index = 0;
      end
    end else if (trk_index >= 2) begin
      if (trk_index == 2) begin
        if (ch == LONG_MARKER) begin
          trk_length = 2 * cfg_long + 5;
        end else if (is_read_function(trk_function)) begin
          trk_length = ch + 5;
        end else begin
          trk_length = FIXED_LENGTH;
        end
      end
      r.accepted = 1'b1;
      r.position = trk_index[IDX_W-1:0];
      r.frame_length = trk_length[LEN_W-1:0];
      if (trk_index + 2 == trk_length) begin
        trk_crc_low = ch;
        trk_index = (trk_index + 1) & 'h1FF;
      end else if (trk_index + 1 == trk_length) begin
        r.frame_end = 1'b1;
        r.frame_good = (trk_crc == {ch, trk_crc_low});
        trk_index = 0;
        trk_crc = '0;
      end else begin
        trk_crc = crc16_update(trk_crc, ch);
        trk_index = (trk_index + 1) & 'h1FF;
      end
    end
    if (r.accepted) r.function_code = trk_function;
    return r;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 8) begin
      rx_ch.valid = 1'b0;
      @(negedge clk);
    end
    rx_ch.valid = 1'b1;
    rx_ch.rx_byte = b;
    do @(posedge clk); while (!rx_ch.ready);
    byte_verdicts.push_back(track_frame_byte(b));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    rx_ch.valid = 1'b0;
    while (byte_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = index;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      REG_DEVICE_ADDRESS: cfg_addr = data;
      REG_LONG_PORTION:   cfg_long = data[LONG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic configure(input logic [BYTE_W-1:0] addr, input logic [CFG_DATA_W-1:0] long_data);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_DEVICE_ADDRESS, addr);
    write_reg(REG_LONG_PORTION, long_data);
  endtask

  // Cut < 1 or >= frame length sends the whole frame; else only the first cut bytes.
  task automatic send_frame(input logic [BYTE_W-1:0] fn, input logic [BYTE_W-1:0] count_byte,
                            input bit corrupt, input int cut);
    logic [BYTE_W-1:0] frame[$];
    logic [CRC_W-1:0]  crc;
    int                total;
    int                n;
    if (count_byte == LONG_MARKER) begin
      total = 2 * cfg_long + 5;
    end else if (is_read_function(fn)) begin
      total = count_byte + 5;
    end else begin
      total = FIXED_LENGTH;
    end
    frame = '{cfg_addr, fn, count_byte};
    while (frame.size() < total - 2) frame.push_back(BYTE_W'($urandom_range(255)));
    crc = CRC_INIT;
    foreach (frame[i]) crc = crc16_update(crc, frame[i]);
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    if (corrupt) begin
      frame[total - 1 - $urandom_range(1)] ^= 8'h01 << $urandom_range(7);
    end
    n = (cut > 0 && cut < total) ? cut : total;
    for (int i = 0; i < n; i++) send_byte(frame[i]);
    frame_bytes_sent += n;
  endtask

  function automatic logic [BYTE_W-1:0] pick_count_byte();
    int r;
    r = $urandom_range(99);
    if (r < 12) return LONG_MARKER;
    if (r < 17) return BYTE_W'($urandom_range(255));
    return BYTE_W'($urandom_range(12));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_bad_function();
    logic [BYTE_W-1:0] code;
    do code = BYTE_W'($urandom_range(255)); while (is_modbus_function(code));
    return code;
  endfunction

  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7E);
  endtask

  task automatic test_restart_at_function();
    send_byte(cfg_addr);
    send_frame(FN_WRITE_REG, 8'h00, 1'b0, 0);
  endtask

  task automatic test_long_marker();
    send_frame(FN_READ_HOLDING, LONG_MARKER, 1'b0, 0);
  endtask

  task automatic test_bad_function();
    send_frame(8'h02, 8'h00, 1'b0, 2);
  endtask

  task automatic test_crc_mismatch();
    send_frame(FN_WRITE_COIL, 8'hFF, 1'b1, 0);
  endtask

  task automatic test_config_extremes();
    logic [BYTE_W-1:0] addrs[4] = '{8'h00, 8'hFF, 8'hA5, LONG_MARKER};
    logic [BYTE_W-1:0] longs[4] = '{8'h00, 8'h7F, 8'h84, 8'h03};
    for (int p = 0; p < 4; p++) begin
      configure(addrs[p], longs[p]);
      if (p == 2) write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(255)));
      send_frame(fn_codes[$urandom_range(7)], LONG_MARKER, 1'b0, 0);
      repeat (2) send_frame(fn_codes[$urandom_range(7)], pick_count_byte(),
                            $urandom_range(4) == 0, 0);
    end
  endtask

  task automatic test_random_traffic();
    int  start;
    int  n;
    int  choice;
    bit  paused;
    paused = 1'b0;
    configure(BYTE_W'($urandom_range(255)), CFG_DATA_W'($urandom_range(20)));
    start = frame_bytes_sent;
    n = 0;
    while (n < RANDOM_BYTES) begin
      calm = (n >= 30 && n < 100);
      if (!paused && n >= 110) begin
        wait_drained();
        paused = 1'b1;
      end
      choice = $urandom_range(99);
      if (choice < 70) begin
        send_frame(fn_codes[$urandom_range(7)], pick_count_byte(), $urandom_range(9) == 0, 0);
      end else if (choice < 80) begin
        send_frame(fn_codes[$urandom_range(7)], pick_count_byte(), 1'b0, $urandom_range(1, 5));
      end else if (choice < 88) begin
        send_frame(pick_bad_function(), 8'h00, 1'b0, 2);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(255)));
      end
      n = frame_bytes_sent - start;
    end
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    res_ch.ready = calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.accepted = res_ch.accepted;
      seen.position = res_ch.position;
      seen.data_byte = res_ch.data_byte;
      seen.frame_end = res_ch.frame_end;
      seen.frame_good = res_ch.frame_good;
      seen.function_code = res_ch.function_code;
      seen.frame_length = res_ch.frame_length;
      if (byte_verdicts.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("Unexpected result transfer for byte %02h", seen.data_byte);
        end
      end else begin
        want = byte_verdicts.pop_front();
        if (seen.accepted !== want.accepted || seen.position !== want.position ||
            seen.data_byte !== want.data_byte || seen.frame_end !== want.frame_end ||
            seen.frame_good !== want.frame_good ||
            seen.function_code !== want.function_code ||
            seen.frame_length !== want.frame_length) begin
          error_count++;
          if (error_count <= 10) begin
            $display("Mismatch: expected acc=%0d pos=%0d byte=%02h end=%0d good=%0d fn=%02h len=%0d",
                     want.accepted, want.position, want.data_byte, want.frame_end,
                     want.frame_good, want.function_code, want.frame_length);
            $display("          actual   acc=%0d pos=%0d byte=%02h end=%0d good=%0d fn=%02h len=%0d",
                     seen.accepted, seen.position, seen.data_byte, seen.frame_end,
                     seen.frame_good, seen.function_code, seen.frame_length);
          end
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    calm = 1'b0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    cfg_addr = DEVICE_ADDRESS_RESET;
    cfg_long = LONG_PORTION_RESET;
    trk_index = 0;
    trk_length = 0;
    trk_function = '0;
    trk_crc = '0;
    trk_crc_low = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_bytes();
    test_restart_at_function();
    test_long_marker();
    test_bad_function();
    test_crc_mismatch();
    test_config_extremes();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0 && byte_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
